### hdl/xcr_pkg.sv
// Package for the XMODEM checksum receiver core: codes, widths and the
// types passed between the configuration, engine and result sequencer.
// No dependencies.
package xcr_pkg;

   // Packet framing: SOH, seq, ~seq, DATA_BYTES data bytes, checksum
   localparam int DATA_BYTES = 128;
   localparam int PKT_LEN    = DATA_BYTES + 4;
   localparam int LAST_POS   = PKT_LEN - 1;
   localparam int POS_W      = $clog2(PKT_LEN);

   // Input modes
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_BYTE  = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   // Protocol bytes
   localparam logic [7:0] CODE_SOH = 8'h01;
   localparam logic [7:0] CODE_EOT = 8'h04;
   localparam logic [7:0] CODE_ACK = 8'h06;
   localparam logic [7:0] CODE_NAK = 8'h15;
   localparam logic [7:0] CODE_CAN = 8'h18;

   // Session end causes
   localparam logic [1:0] CAUSE_SENDER  = 2'd0;
   localparam logic [1:0] CAUSE_BUDGET  = 2'd1;
   localparam logic [1:0] CAUSE_RETRIES = 2'd2;
   localparam logic [1:0] CAUSE_SEQ     = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_BYTE_BUDGET   = 2'd0;
   localparam logic [1:0] CSR_RETRY_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd2;

   // Configuration reset values
   localparam logic [23:0] BUDGET_RESET  = 24'hFFFFFF;
   localparam logic [7:0]  RETRY_RESET   = 8'd10;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [23:0] byte_budget;
      logic [7:0]  retry_limit;
      logic [15:0] timeout_ticks;
   } cfg_type;

   // Shape of the result sequence caused by one input word
   typedef enum logic [1:0] {
      KIND_SINGLE,      // one result, fields as stored
      KIND_CANCEL,      // CAN, CAN, ACK with done
      KIND_COMMIT_FIN   // ACK with commit, then ACK with done
   } kind_type;

   typedef struct packed {
      logic        reply_valid;
      logic [7:0]  reply_byte;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [6:0]  data_index;
      logic        commit;
      logic [7:0]  commit_count;
      logic        done_res;
      logic [23:0] total_bytes;
      logic [1:0]  end_cause;
   } rec_type;

   typedef struct packed {
      kind_type kind;
      rec_type  rec;
   } bundle_type;

endpackage

### hdl/xcr_if.sv
// Channel interfaces of the XMODEM checksum receiver core.
// Depends on nothing; payload widths follow the field list.
interface xcr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface xcr_rsp_if;
   logic        valid;
   logic        ready;
   logic        reply_valid;
   logic [7:0]  reply_byte;
   logic        data_valid;
   logic [7:0]  data_byte;
   logic [6:0]  data_index;
   logic        commit;
   logic [7:0]  commit_count;
   logic        done_res;
   logic [23:0] total_bytes;
   logic [1:0]  end_cause;
   logic        last;

   modport source (output valid, output reply_valid, output reply_byte,
                   output data_valid, output data_byte, output data_index,
                   output commit, output commit_count, output done_res,
                   output total_bytes, output end_cause, output last,
                   input ready);
   modport sink   (input valid, input reply_valid, input reply_byte,
                   input data_valid, input data_byte, input data_index,
                   input commit, input commit_count, input done_res,
                   input total_bytes, input end_cause, input last,
                   output ready);
endinterface

### hdl/xcr_csr.sv
// Configuration registers of the XMODEM checksum receiver core.
// Depends on xcr_pkg.
module xcr_csr
   import xcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_BYTE_BUDGET:   cfg_in.byte_budget   = csr_wdata;
            CSR_RETRY_LIMIT:   cfg_in.retry_limit   = csr_wdata[7:0];
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.byte_budget   <= BUDGET_RESET;
         cfg_ff.retry_limit   <= RETRY_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/xcr_engine.sv
// Session engine: packet framing, checksum, sequence and retry logic.
// Updates state on each accepted word and hands a result bundle onward.
// Depends on xcr_pkg.
module xcr_engine
   import xcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_take,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_byte,
   output logic       load_valid,
   output bundle_type load_bundle
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       seq_ff, seq_in;
   logic [7:0]       prev_seq_ff, prev_seq_in;
   logic [7:0]       retry_count_ff, retry_count_in;
   logic [15:0]      timeout_ff, timeout_in;
   logic [23:0]      budget_ff, budget_in;
   logic [23:0]      total_ff, total_in;
   logic             over_ff, over_in;

   logic [8:0]         retry_next;
   logic               retry_over;
   logic               do_retry;
   logic [23:0]        count;
   logic [23:0]        budget_after;
   logic [POS_W+6:0]   idx_wide;

   assign retry_next   = {1'b0, retry_count_ff} + 9'd1;
   assign retry_over   = retry_next > {1'b0, cfg.retry_limit};
   assign count        = (budget_ff < 24'(DATA_BYTES)) ? budget_ff : 24'(DATA_BYTES);
   assign budget_after = budget_ff - count;
   assign idx_wide     = {7'd0, pos_ff} - (POS_W+7)'(3);

   always_comb begin
      pos_in         = pos_ff;
      sum_in         = sum_ff;
      seq_in         = seq_ff;
      prev_seq_in    = prev_seq_ff;
      retry_count_in = retry_count_ff;
      timeout_in     = timeout_ff;
      budget_in      = budget_ff;
      total_in       = total_ff;
      over_in        = over_ff;
      do_retry       = 1'b0;
      load_valid     = 1'b0;
      load_bundle    = '0;
      load_bundle.kind = KIND_SINGLE;

      if (req_take) begin
         case (req_mode)
            MODE_START: begin
               pos_in         = '0;
               sum_in         = '0;
               seq_in         = '0;
               prev_seq_in    = '0;
               retry_count_in = '0;
               timeout_in     = '0;
               budget_in      = cfg.byte_budget;
               total_in       = '0;
               over_in        = 1'b0;
            end
            MODE_TICK: begin
               if (!over_ff) begin
                  if (timeout_ff > 16'd1) begin
                     timeout_in = timeout_ff - 16'd1;
                  end else begin
                     // expiry: reload, drop the partial packet
                     timeout_in = cfg.timeout_ticks;
                     pos_in     = '0;
                     do_retry   = 1'b1;
                  end
               end
            end
            MODE_BYTE: begin
               if (!over_ff) begin
                  timeout_in = cfg.timeout_ticks;
                  if (pos_ff == '0) begin
                     sum_in = '0;
                     if (req_byte == CODE_SOH) begin
                        pos_in = POS_W'(1);
                     end else if (req_byte == CODE_EOT || req_byte == CODE_CAN) begin
                        over_in                      = 1'b1;
                        load_valid                   = 1'b1;
                        load_bundle.rec.reply_valid  = 1'b1;
                        load_bundle.rec.reply_byte   = CODE_ACK;
                        load_bundle.rec.done_res     = 1'b1;
                        load_bundle.rec.end_cause    = CAUSE_SENDER;
                     end
                  end else if (pos_ff == POS_W'(1)) begin
                     seq_in = req_byte;
                     pos_in = POS_W'(2);
                  end else if (pos_ff == POS_W'(2)) begin
                     pos_in = (~seq_ff == req_byte) ? POS_W'(3) : '0;
                  end else if (pos_ff < POS_W'(LAST_POS)) begin
                     sum_in                     = sum_ff + req_byte;
                     pos_in                     = pos_ff + POS_W'(1);
                     load_valid                 = 1'b1;
                     load_bundle.rec.data_valid = 1'b1;
                     load_bundle.rec.data_byte  = req_byte;
                     load_bundle.rec.data_index = idx_wide[6:0];
                  end else begin
                     // checksum byte closes the packet
                     pos_in = '0;
                     if (req_byte != sum_ff) begin
                        do_retry = 1'b1;
                     end else if (seq_ff == prev_seq_ff) begin
                        load_valid                  = 1'b1;
                        load_bundle.rec.reply_valid = 1'b1;
                        load_bundle.rec.reply_byte  = CODE_ACK;
                     end else if (prev_seq_ff + 8'd1 != seq_ff) begin
                        over_in                   = 1'b1;
                        load_valid                = 1'b1;
                        load_bundle.kind          = KIND_CANCEL;
                        load_bundle.rec.end_cause = CAUSE_SEQ;
                     end else begin
                        budget_in                    = budget_after;
                        total_in                     = total_ff + count;
                        prev_seq_in                  = seq_ff;
                        retry_count_in               = '0;
                        load_valid                   = 1'b1;
                        load_bundle.rec.reply_valid  = 1'b1;
                        load_bundle.rec.reply_byte   = CODE_ACK;
                        load_bundle.rec.commit       = 1'b1;
                        load_bundle.rec.commit_count = count[7:0];
                        if (budget_after == '0) begin
                           over_in                   = 1'b1;
                           load_bundle.kind          = KIND_COMMIT_FIN;
                           load_bundle.rec.end_cause = CAUSE_BUDGET;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end

      if (do_retry) begin
         load_valid = 1'b1;
         if (retry_over) begin
            over_in                   = 1'b1;
            load_bundle.kind          = KIND_CANCEL;
            load_bundle.rec.end_cause = CAUSE_RETRIES;
         end else begin
            retry_count_in              = retry_next[7:0];
            load_bundle.rec.reply_valid = 1'b1;
            load_bundle.rec.reply_byte  = CODE_NAK;
         end
      end

      load_bundle.rec.total_bytes = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         sum_ff         <= '0;
         seq_ff         <= '0;
         prev_seq_ff    <= '0;
         retry_count_ff <= '0;
         timeout_ff     <= '0;
         budget_ff      <= BUDGET_RESET;
         total_ff       <= '0;
         over_ff        <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         sum_ff         <= sum_in;
         seq_ff         <= seq_in;
         prev_seq_ff    <= prev_seq_in;
         retry_count_ff <= retry_count_in;
         timeout_ff     <= timeout_in;
         budget_ff      <= budget_in;
         total_ff       <= total_in;
         over_ff        <= over_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(LAST_POS))
      else $error("packet position beyond the checksum byte");

   a_over_silent: assert property (@(posedge clock) disable iff (reset)
      over_ff && req_mode != MODE_START |-> !load_valid)
      else $error("result produced after the session ended");

endmodule

### hdl/xcr_out.sv
// Result sequencer: holds one result bundle and plays it out as one to
// three response words. Depends on xcr_pkg and xcr_rsp_if.
module xcr_out
   import xcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   input  bundle_type load_bundle,
   output logic       can_load,
   xcr_rsp_if.source  rsp
);

   bundle_type bund_ff, bund_in;
   logic       valid_ff, valid_in;
   logic [1:0] step_ff, step_in;
   logic       is_last;
   logic       rsp_take;

   always_comb begin
      case (bund_ff.kind)
         KIND_CANCEL:     is_last = (step_ff == 2'd2);
         KIND_COMMIT_FIN: is_last = (step_ff == 2'd1);
         default:         is_last = 1'b1;
      endcase
   end

   assign rsp_take = valid_ff && rsp.ready;
   assign can_load = !valid_ff || (rsp_take && is_last);

   always_comb begin
      bund_in  = bund_ff;
      valid_in = valid_ff;
      step_in  = step_ff;
      if (load_valid) begin
         bund_in  = load_bundle;
         valid_in = 1'b1;
         step_in  = 2'd0;
      end else if (rsp_take) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      bund_ff <= bund_in;
   end

   // Per-step field selection
   always_comb begin
      rsp.valid        = valid_ff;
      rsp.last         = is_last;
      rsp.reply_valid  = bund_ff.rec.reply_valid;
      rsp.reply_byte   = bund_ff.rec.reply_byte;
      rsp.data_valid   = bund_ff.rec.data_valid;
      rsp.data_byte    = bund_ff.rec.data_byte;
      rsp.data_index   = bund_ff.rec.data_index;
      rsp.commit       = bund_ff.rec.commit;
      rsp.commit_count = bund_ff.rec.commit_count;
      rsp.done_res     = bund_ff.rec.done_res;
      rsp.total_bytes  = bund_ff.rec.total_bytes;
      rsp.end_cause    = bund_ff.rec.end_cause;
      case (bund_ff.kind)
         KIND_CANCEL: begin
            rsp.reply_valid = 1'b1;
            rsp.reply_byte  = is_last ? CODE_ACK : CODE_CAN;
            rsp.done_res    = is_last;
            rsp.end_cause   = is_last ? bund_ff.rec.end_cause : CAUSE_SENDER;
         end
         KIND_COMMIT_FIN: begin
            rsp.reply_valid  = 1'b1;
            rsp.reply_byte   = CODE_ACK;
            rsp.commit       = !is_last;
            rsp.commit_count = is_last ? 8'd0 : bund_ff.rec.commit_count;
            rsp.done_res     = is_last;
            rsp.end_cause    = is_last ? bund_ff.rec.end_cause : CAUSE_SENDER;
         end
         default: ;
      endcase
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_valid |-> (!valid_ff || (rsp_take && is_last)))
      else $error("bundle loaded over a pending result");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> step_ff != 2'd3)
      else $error("result step out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp.ready |=> valid_ff && $stable(step_ff))
      else $error("result sequence advanced while stalled");

endmodule

### hdl/xmodem_checksum_receiver_core.sv
// Top level of the XMODEM receiver with 8-bit checksum.
// Depends on xcr_pkg, xcr_if, xcr_csr, xcr_engine and xcr_out.
//
// Usage:
//   req_chan carries one word per handshake: mode 0 is a tick of time,
//   mode 1 a received byte (rx_byte), mode 2 starts a new session.
//   rsp_chan returns the result words each input word causes: a tentative
//   data byte, a reply (ACK/NAK/CAN), a packet commit or the session end;
//   last marks the final result word of one input word.
//   csr_* writes byte_budget (0), retry_limit (1), timeout_ticks (2); write
//   only while the block is idle.
// Timing:
//   A word that causes results shows its first result in the cycle after
//   it is accepted, from the result register. Words producing a single
//   result or none flow at one per cycle while rsp_chan.ready is high. A
//   cancel (CAN, CAN, ACK) holds the result register for three words and
//   a final commit (ACK, ACK) for two, played out by the result sequencer.
//   req_chan.ready stays low until the final word of the sequence is taken,
//   so the next word goes in only then.
// Reset:
//   Registers return to their defaults and a session is running with the
//   timeout counter at zero, so the first tick sends NAK.
// Stall:
//   While rsp_chan.ready is low the pending result holds, and new words are
//   held off once a result waits.
module xmodem_checksum_receiver_core
   import xcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   xcr_req_if.sink     req_chan,
   xcr_rsp_if.source   rsp_chan
);

   cfg_type    cfg;
   logic       can_load;
   logic       req_take;
   logic       load_valid;
   bundle_type load_bundle;

   // Accept a word whenever the result register is free or empties now
   assign req_chan.ready = can_load;
   assign req_take       = req_chan.valid && can_load;

   xcr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   xcr_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_take    (req_take),
      .req_mode    (req_chan.mode),
      .req_byte    (req_chan.rx_byte),
      .load_valid  (load_valid),
      .load_bundle (load_bundle)
   );

   xcr_out u_out (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (load_valid),
      .load_bundle (load_bundle),
      .can_load    (can_load),
      .rsp         (rsp_chan)
   );

endmodule
